>>> sv/dual_midi_clock_tick_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// dual_midi_clock_tick_scheduler_top_defines
// assertion macros for the dual midi clock tick scheduler
// ----------------------------------------------------------------------------
`ifndef DUAL_MIDI_CLOCK_TICK_SCHEDULER_TOP_DEFINES_SVH
`define DUAL_MIDI_CLOCK_TICK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked at every rising edge outside reset
`define DMCTS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define DMCTS_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DMCTS_ASSERT(name, clk, rst_n, prop, msg)
`define DMCTS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> sv/dmcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmcts_pkg
// shared types and constants of the dual midi clock tick scheduler
// ----------------------------------------------------------------------------
package dmcts_pkg;

	localparam int unsigned NOW_W    = 32;
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned COUNT_W  = 8;

	localparam logic [COUNT_W-1:0] TICKS_PER_STEP_RST = 8'd96;

	typedef enum logic [1:0] {
		OP_POLL   = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_UPDATE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 opcode;
		logic [NOW_W-1:0]    now_time;
		logic [PERIOD_W-1:0] master_period;
		logic [PERIOD_W-1:0] poly_period;
		logic                paused_flag;
	} in_item_t;

	typedef struct packed {
		logic master_pulse;
		logic poly_pulse;
		logic step_event;
		logic send_start;
		logic send_stop;
	} out_item_t;

endpackage

>>> sv/dual_midi_clock_tick_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_midi_clock_tick_scheduler_top
// master and poly midi clock schedulers driven by poll and command items
//
//   channel   direction  handshake            payload
//   in        to block   in_valid / in_stall    in_item (in_item_t)
//   out       from block out_valid / out_stall  out_item (out_item_t)
//   cfg       to block   cfg_we               cfg_data (ticks_per_step)
//
// one item per cycle while the result side is not stalled; each input transfer yields one result
// the input register feeds the scheduler, which updates its state and loads
// the result register in the same cycle, so the next item sees the new state
// a stalled result holds the result register; the input register then holds too
// and in_stall rises; no reset sweep, the block takes items right after reset
// ----------------------------------------------------------------------------
`include "dual_midi_clock_tick_scheduler_top_defines.svh"

module dual_midi_clock_tick_scheduler_top import dmcts_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_item,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_data
);

	logic               valid_s1;
	in_item_t           item_s1;
	logic               valid_s2;
	out_item_t          item_s2;
	logic [COUNT_W-1:0] ticks_per_step_q;

	logic      out_free;
	logic      advance;
	logic      in_xfer;
	out_item_t result;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_step_q <= TICKS_PER_STEP_RST;
		end else if (cfg_we) begin
			ticks_per_step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_item;
		end
	end

	dmcts_sched #(
		.TIME_BITS (TIME_BITS)
	) u_sched (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.item           (item_s1),
		.ticks_per_step (ticks_per_step_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// input side only backs up when the result register is full and stalled
	`DMCTS_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall), "in_stall without a stalled result")

	// an accepted stop while paused shows up in the next result
	`DMCTS_ASSERT(a_stop_result, clk, arst_n, (advance && item_s1.opcode == OP_STOP && item_s1.paused_flag) |=> (out_valid && out_item.send_stop), "stop transfer lost")

	// pulses and commands never share a result
	`DMCTS_ASSERT(a_pulse_cmd_excl, clk, arst_n, out_valid |-> !((out_item.master_pulse || out_item.poly_pulse || out_item.step_event) && (out_item.send_start || out_item.send_stop)), "pulse and command in one result")

	// a step event always comes with a master pulse
	`DMCTS_ASSERT(a_step_pulse, clk, arst_n, (out_valid && out_item.step_event) |-> out_item.master_pulse, "step event without master pulse")

endmodule

>>> sv/dmcts_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmcts_sched
// scheduler state and next-state logic, one item per enabled cycle
// ----------------------------------------------------------------------------
module dmcts_sched import dmcts_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  in_item_t            item,
	input  logic [COUNT_W-1:0]  ticks_per_step,
	output out_item_t           result
);

	localparam int SUM_W = TIME_BITS + PERIOD_W;

	// wrap-safe: a - b taken as signed is not negative
	function automatic logic not_before(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] d;
		d = a - b;
		return !d[TIME_BITS-1];
	endfunction

	function automatic logic [TIME_BITS-1:0] add_period(input logic [TIME_BITS-1:0] t,
		input logic [PERIOD_W-1:0] p);
		logic [SUM_W-1:0] s;
		s = SUM_W'(t) + SUM_W'(p);
		return s[TIME_BITS-1:0];
	endfunction

	logic                 m_active_q, p_active_q;
	logic [TIME_BITS-1:0] m_deadline_q, p_deadline_q;
	logic [PERIOD_W-1:0]  m_interval_q, p_interval_q;
	logic [COUNT_W-1:0]   m_count_q;

	logic                 m_active_d, p_active_d;
	logic [TIME_BITS-1:0] m_deadline_d, p_deadline_d;
	logic [PERIOD_W-1:0]  m_interval_d, p_interval_d;
	logic [COUNT_W-1:0]   m_count_d;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] m_target, p_target;
	logic [COUNT_W-1:0]   count_inc;
	logic                 m_due, p_due;

	assign now_t     = TIME_BITS'(item.now_time);
	assign m_target  = add_period(now_t, item.master_period);
	assign p_target  = add_period(now_t, item.poly_period);
	assign count_inc = m_count_q + COUNT_W'(1);
	assign m_due     = m_active_q && not_before(now_t, m_deadline_q);
	assign p_due     = p_active_q && not_before(now_t, p_deadline_q);

	always_comb begin
		m_active_d   = m_active_q;
		p_active_d   = p_active_q;
		m_deadline_d = m_deadline_q;
		p_deadline_d = p_deadline_q;
		m_interval_d = m_interval_q;
		p_interval_d = p_interval_q;
		m_count_d    = m_count_q;
		result       = '0;
		unique case (item.opcode)
			OP_POLL: begin
				if (m_due) begin
					result.master_pulse = 1'b1;
					m_deadline_d        = add_period(m_deadline_q, m_interval_q);
					if (count_inc >= ticks_per_step) begin
						m_count_d         = '0;
						result.step_event = 1'b1;
					end else begin
						m_count_d = count_inc;
					end
				end
				if (p_due) begin
					result.poly_pulse = 1'b1;
					p_deadline_d      = add_period(p_deadline_q, p_interval_q);
				end
			end
			OP_START: begin
				if (!item.paused_flag) begin
					if (!m_active_q) begin
						m_active_d   = 1'b1;
						p_active_d   = 1'b1;
						m_count_d    = '0;
						m_deadline_d = m_target;
						m_interval_d = item.master_period;
					end
					// resync of a running master touches only the poly clock
					p_deadline_d      = p_target;
					p_interval_d      = item.poly_period;
					result.send_start = 1'b1;
				end
			end
			OP_STOP: begin
				if (item.paused_flag) begin
					m_active_d       = 1'b0;
					p_active_d       = 1'b0;
					result.send_stop = 1'b1;
				end
			end
			OP_UPDATE: begin
				m_interval_d = item.master_period;
				p_interval_d = item.poly_period;
				// deadlines only move earlier
				if (m_deadline_q != m_target && not_before(m_deadline_q, m_target)) begin
					m_deadline_d = m_target;
				end
				if (p_deadline_q != p_target && not_before(p_deadline_q, p_target)) begin
					p_deadline_d = p_target;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_active_q   <= 1'b0;
			p_active_q   <= 1'b0;
			m_deadline_q <= '0;
			p_deadline_q <= '0;
			m_interval_q <= '0;
			p_interval_q <= '0;
			m_count_q    <= '0;
		end else if (en) begin
			m_active_q   <= m_active_d;
			p_active_q   <= p_active_d;
			m_deadline_q <= m_deadline_d;
			p_deadline_q <= p_deadline_d;
			m_interval_q <= m_interval_d;
			p_interval_q <= p_interval_d;
			m_count_q    <= m_count_d;
		end
	end

endmodule

>>> tb/dual_midi_clock_tick_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_midi_clock_tick_scheduler_top_tb
// self-checking bench for the master / poly midi clock tick scheduler
//
// a behavioral copy of the two schedulers predicts the pulse, step, start and
// stop flags of every accepted item; results are checked in order as they
// leave the block. directed items walk through refused commands, deadline
// hits across the time wrap, resync, tempo updates and zero periods, then
// random start / poll / update / stop traffic runs under several step counts
// with random idling on both sides and one long hold on the result side
// ----------------------------------------------------------------------------
module dual_midi_clock_tick_scheduler_top_tb import dmcts_pkg::*; ;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 48;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_item;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_data;

	// scheduler state as the block should hold it
	logic                master_on;
	logic                poly_on;
	logic [NOW_W-1:0]    master_due;
	logic [NOW_W-1:0]    poly_due;
	logic [PERIOD_W-1:0] master_gap;
	logic [PERIOD_W-1:0] poly_gap;
	logic [COUNT_W-1:0]  master_pulses;
	logic [COUNT_W-1:0]  steps_cfg;

	out_item_t        pending_events[$];
	logic [NOW_W-1:0] wall_us;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;
	int idle_cycles;
	int mismatch_count;
	int items_sent;
	int results_seen;
	int master_seen;
	int poly_seen;
	int steps_seen;
	int starts_seen;
	int stops_seen;

	dual_midi_clock_tick_scheduler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// wrap-safe: now minus due, read as signed, is not negative
	function automatic bit reached(logic [NOW_W-1:0] now, logic [NOW_W-1:0] due);
		logic [NOW_W-1:0] diff;
		diff = now - due;
		return diff[NOW_W-1] == 1'b0;
	endfunction

	function automatic out_item_t predict_clock_events(in_item_t it);
		out_item_t        r;
		logic [NOW_W-1:0] mt;
		logic [NOW_W-1:0] pt;
		r = '0;
		case (it.opcode)
			OP_POLL: begin
				if (master_on && reached(it.now_time, master_due)) begin
					r.master_pulse = 1'b1;
					master_due     = master_due + master_gap;
					master_pulses  = master_pulses + 1'b1;
					if (master_pulses >= steps_cfg) begin
						master_pulses = '0;
						r.step_event  = 1'b1;
					end
				end
				if (poly_on && reached(it.now_time, poly_due)) begin
					r.poly_pulse = 1'b1;
					poly_due     = poly_due + poly_gap;
				end
			end
			OP_START: begin
				if (!it.paused_flag) begin
					if (!master_on) begin
						master_on     = 1'b1;
						poly_on       = 1'b1;
						master_pulses = '0;
						master_due    = it.now_time + it.master_period;
						master_gap    = it.master_period;
					end
					poly_due     = it.now_time + it.poly_period;
					poly_gap     = it.poly_period;
					r.send_start = 1'b1;
				end
			end
			OP_STOP: begin
				if (it.paused_flag) begin
					master_on   = 1'b0;
					poly_on     = 1'b0;
					r.send_stop = 1'b1;
				end
			end
			OP_UPDATE: begin
				mt         = it.now_time + it.master_period;
				pt         = it.now_time + it.poly_period;
				master_gap = it.master_period;
				poly_gap   = it.poly_period;
				// deadlines only ever move earlier
				if (master_due != mt && reached(master_due, mt))
					master_due = mt;
				if (poly_due != pt && reached(poly_due, pt))
					poly_due = pt;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic compare_flag(string name, logic got, logic want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s expected %b got %b",
				results_seen, name, want, got));
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (pending_events.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing pending",
				results_seen));
		end else begin
			want = pending_events.pop_front();
			compare_flag("master_pulse", got.master_pulse, want.master_pulse);
			compare_flag("poly_pulse", got.poly_pulse, want.poly_pulse);
			compare_flag("step_event", got.step_event, want.step_event);
			compare_flag("send_start", got.send_start, want.send_start);
			compare_flag("send_stop", got.send_stop, want.send_stop);
		end
		results_seen++;
		master_seen += got.master_pulse;
		poly_seen   += got.poly_pulse;
		steps_seen  += got.step_event;
		starts_seen += got.send_start;
		stops_seen  += got.send_stop;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_item);
	end

	// result side: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// called and returns right after a rising edge
	task automatic send_item(in_item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_events.push_back(predict_clock_events(it));
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ticks_per_step(logic [COUNT_W-1:0] value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		steps_cfg = value;
	endtask

	function automatic in_item_t make_item(op_t op, logic [NOW_W-1:0] now,
			logic [PERIOD_W-1:0] mp, logic [PERIOD_W-1:0] pp, logic paused);
		in_item_t it;
		it.opcode        = op;
		it.now_time      = now;
		it.master_period = mp;
		it.poly_period   = pp;
		it.paused_flag   = paused;
		return it;
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period();
		logic [PERIOD_W-1:0] p;
		int unsigned         r;
		r = $urandom_range(99);
		if (r < 3)
			p = '0;
		else if (r < 9)
			p = PERIOD_W'($urandom);
		else
			p = PERIOD_W'($urandom_range(1, 40));
		return p;
	endfunction

	// mostly a running session: start, polls on advancing time, some updates
	function automatic in_item_t next_random_item(int unsigned stop_pct);
		in_item_t    it;
		int unsigned r;
		wall_us           = wall_us + $urandom_range(0, 48);
		it.now_time       = wall_us;
		it.master_period  = pick_period();
		it.poly_period    = pick_period();
		it.paused_flag    = 1'($urandom_range(1));
		it.opcode         = OP_POLL;
		r = $urandom_range(99);
		if ($urandom_range(99) < 3) begin
			it.opcode   = op_t'($urandom_range(3));
			it.now_time = $urandom;
		end else if (!master_on) begin
			if (r < 40) begin
				it.opcode      = OP_START;
				it.paused_flag = $urandom_range(99) < 10;
			end
		end else if (r < stop_pct) begin
			it.opcode      = OP_STOP;
			it.paused_flag = $urandom_range(99) < 85;
		end else if (r < stop_pct + 4) begin
			it.opcode      = OP_START;
			it.paused_flag = $urandom_range(99) < 15;
		end else if (r < stop_pct + 10) begin
			it.opcode = OP_UPDATE;
		end
		return it;
	endfunction

	task automatic test_directed();
		send_item(make_item(OP_POLL, 32'h0000_0000, 24'h000000, 24'h000000, 1'b0));
		// stop needs pause set, then stop while already stopped
		send_item(make_item(OP_STOP, 32'h0000_0001, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
		send_item(make_item(OP_STOP, 32'h0000_0002, 24'h000000, 24'h000000, 1'b1));
		send_item(make_item(OP_START, 32'hFFFF_FF00, 24'h000010, 24'h000020, 1'b1));
		send_item(make_item(OP_START, 32'hFFFF_FF00, 24'h000010, 24'h000020, 1'b0));
		send_item(make_item(OP_POLL, 32'hFFFF_FF0F, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_POLL, 32'hFFFF_FF10, 24'h000000, 24'h000000, 1'b1));
		send_item(make_item(OP_POLL, 32'hFFFF_FF20, 24'h000000, 24'h000000, 1'b0));
		// resync while running, poly deadline wraps past zero
		send_item(make_item(OP_START, 32'hFFFF_FF30, 24'hFFFFFF, 24'h000100, 1'b0));
		send_item(make_item(OP_UPDATE, 32'hFFFF_FF30, 24'h000005, 24'hFFFFFF, 1'b0));
		send_item(make_item(OP_UPDATE, 32'hFFFF_FF20, 24'h000005, 24'h000001, 1'b0));
		send_item(make_item(OP_UPDATE, 32'hFFFF_FF20, 24'h000005, 24'h000001, 1'b1));
		send_item(make_item(OP_POLL, 32'h0000_0000, 24'h000000, 24'h000000, 1'b0));
		// zero periods fire on every poll
		send_item(make_item(OP_STOP, 32'h0000_0003, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
		send_item(make_item(OP_START, 32'h0000_0010, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_POLL, 32'h0000_0010, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_POLL, 32'h0000_0010, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
		// largest positive and first negative distance from the deadline
		send_item(make_item(OP_POLL, 32'h8000_000F, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_POLL, 32'h8000_0010, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
		send_item(make_item(OP_START, 32'h7FFF_FFFF, 24'h000001, 24'h000002, 1'b0));
		send_item(make_item(OP_POLL, 32'hFFFF_FFFF, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_STOP, 32'hFFFF_FFFF, 24'h000000, 24'h000000, 1'b0));
		send_item(make_item(OP_STOP, 32'hFFFF_FFFF, 24'h000000, 24'h000000, 1'b1));
		send_item(make_item(OP_POLL, 32'hFFFF_FFFF, 24'h000000, 24'h000000, 1'b0));
	endtask

	// step count of zero and one: every master pulse is a step
	task automatic test_step_extremes();
		logic [COUNT_W-1:0] value;
		for (int k = 0; k < 2; k++) begin
			value = COUNT_W'(k);
			write_ticks_per_step(value);
			send_item(make_item(OP_STOP, 32'd900, 24'd0, 24'd0, 1'b1));
			send_item(make_item(OP_START, 32'd1000, 24'd1, 24'd3, 1'b0));
			for (int i = 1; i <= 6; i++)
				send_item(make_item(OP_POLL, 32'd1000 + i, 24'd0, 24'd0, 1'b0));
		end
	endtask

	task automatic test_random_traffic(int count, logic [COUNT_W-1:0] steps,
			int unsigned stop_pct, logic [NOW_W-1:0] start_us);
		write_ticks_per_step(steps);
		wall_us = start_us;
		repeat (count)
			send_item(next_random_item(stop_pct));
	endtask

	// result side holds for a long stretch while items keep coming
	task automatic test_backpressure();
		write_ticks_per_step(8'd2);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wall_us       = $urandom;
		hold_req      = 1'b1;
		repeat (60)
			send_item(next_random_item(3));
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_item        = '0;
		cfg_we         = 1'b0;
		cfg_data       = '0;
		hold_req       = 1'b0;
		hold_left      = 0;
		idle_cycles    = 0;
		mismatch_count = 0;
		master_on      = 1'b0;
		poly_on        = 1'b0;
		master_due     = '0;
		poly_due       = '0;
		master_gap     = '0;
		poly_gap       = '0;
		master_pulses  = '0;
		steps_cfg      = TICKS_PER_STEP_RST;
		send_idle_pct  = 33;
		recv_idle_pct  = 73;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_step_extremes();
		test_random_traffic(450, 8'd5, 3, $urandom);
		send_idle_pct = 73;
		recv_idle_pct = 33;
		test_random_traffic(450, 8'd255, 0, 32'hFFFF_E000 + $urandom_range(0, 4095));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(450, 8'd24, 3, $urandom);
		test_backpressure();
		wait_drained();

		$display("%0d items, %0d results, step counts 96/0/1/5/255/24/2, %0d mismatches",
			items_sent, results_seen, mismatch_count);
		$display("seen: %0d master pulses, %0d poly pulses, %0d steps, %0d starts, %0d stops",
			master_seen, poly_seen, steps_seen, starts_seen, stops_seen);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/dmcts_pkg.sv
sv/dmcts_sched.sv
sv/dual_midi_clock_tick_scheduler_top.sv
tb/dual_midi_clock_tick_scheduler_top_tb.sv
